>>> hdl/aas_pkg.sv
package aas_pkg;

  // Field widths fixed by the interface
  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned LenW      = 7;
  localparam int unsigned ReqBytesW = 4;
  localparam int unsigned OwnerW    = 8;
  localparam int unsigned CountOutW = 16;
  localparam int unsigned WindowW   = 32;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned PaddrW    = 4;

  // Parameter defaults
  localparam int unsigned MaxAccessBytesDef = 64;
  localparam int unsigned CountWidthDef     = 16;

  // Register reset values
  localparam logic [OwnerW-1:0]  ThreadIdRst   = '0;
  localparam logic               HasIportRst   = 1'b0;
  localparam logic [WindowW-1:0] WindowBaseRst = 32'hF000_0000;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] RegThreadId   = 2'd0;
  localparam logic [1:0] RegHasIport   = 2'd1;
  localparam logic [1:0] RegWindowBase = 2'd2;

  // Opcodes
  localparam logic [OpcodeW-1:0] OpAccess      = 3'd0;
  localparam logic [OpcodeW-1:0] OpAtomicBegin = 3'd1;
  localparam logic [OpcodeW-1:0] OpXlateBegin  = 3'd2;
  localparam logic [OpcodeW-1:0] OpRetired     = 3'd3;
  localparam logic [OpcodeW-1:0] OpResponse    = 3'd4;

  // Lock phases
  localparam logic [1:0] LockNone      = 2'd0;
  localparam logic [1:0] LockReadPend  = 2'd1;
  localparam logic [1:0] LockWritePend = 2'd2;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [AddrW-1:0]   phys_address;
    logic [LenW-1:0]    byte_count;
    logic               is_write;
    logic               virt_nonzero;
  } in_item_t;

  typedef struct packed {
    logic                 has_request;
    logic [AddrW-1:0]     req_address;
    logic [ReqBytesW-1:0] req_bytes;
    logic                 req_write;
    logic                 req_locked;
    logic [OwnerW-1:0]    req_owner;
    logic                 to_instruction_port;
    logic                 stall_now;
    logic [CountOutW-1:0] outstanding_now;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [OwnerW-1:0]  thread_id;
    logic               has_instruction_port;
    logic [WindowW-1:0] device_window_base;
  } cfg_t;

endpackage

>>> hdl/aas_cfg.sv
module aas_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aas_pkg::PaddrW-1:0]    paddr,
  input  logic [aas_pkg::ApbDataW-1:0]  pwdata,
  output logic [aas_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output aas_pkg::cfg_t                 cfg_o
);

  aas_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        aas_pkg::RegThreadId:   cfg_d.thread_id = pwdata[aas_pkg::OwnerW-1:0];
        aas_pkg::RegHasIport:   cfg_d.has_instruction_port = pwdata[0];
        aas_pkg::RegWindowBase: cfg_d.device_window_base = pwdata[aas_pkg::WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aas_pkg::RegThreadId:   prdata = aas_pkg::ApbDataW'(cfg_q.thread_id);
      aas_pkg::RegHasIport:   prdata = aas_pkg::ApbDataW'(cfg_q.has_instruction_port);
      aas_pkg::RegWindowBase: prdata = aas_pkg::ApbDataW'(cfg_q.device_window_base);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thread_id            <= aas_pkg::ThreadIdRst;
      cfg_q.has_instruction_port <= aas_pkg::HasIportRst;
      cfg_q.device_window_base   <= aas_pkg::WindowBaseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/aas_chunk.sv
module aas_chunk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [aas_pkg::AddrW-1:0]      addr_i,
  input  logic [aas_pkg::LenW-1:0]       len_i,
  output logic [aas_pkg::AddrW-1:0]      addr_o,
  output logic [aas_pkg::ReqBytesW-1:0]  inc_o,
  output logic                           pending_o,
  output logic                           last_o
);

  logic [aas_pkg::AddrW-1:0] addr_q, addr_d;
  logic [aas_pkg::LenW-1:0]  rem_q, rem_d, rem_next;
  logic [aas_pkg::ReqBytesW-1:0] inc;

  // Largest naturally aligned size that still fits the remaining length
  always_comb begin
    if (rem_q >= aas_pkg::LenW'(8) && addr_q[2:0] == 3'b000) begin
      inc = aas_pkg::ReqBytesW'(8);
    end else if (rem_q >= aas_pkg::LenW'(4) && addr_q[1:0] == 2'b00) begin
      inc = aas_pkg::ReqBytesW'(4);
    end else if (rem_q >= aas_pkg::LenW'(2) && !addr_q[0]) begin
      inc = aas_pkg::ReqBytesW'(2);
    end else begin
      inc = aas_pkg::ReqBytesW'(1);
    end
  end

  assign rem_next = rem_q - aas_pkg::LenW'(inc);

  always_comb begin
    addr_d = addr_q;
    rem_d  = rem_q;
    if (load_i) begin
      addr_d = addr_i;
      rem_d  = len_i;
    end else if (step_i) begin
      addr_d = addr_q + aas_pkg::AddrW'(inc);
      rem_d  = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  assign addr_o    = addr_q;
  assign inc_o     = inc;
  assign pending_o = (rem_q != '0);
  assign last_o    = (rem_next == '0);

endmodule

>>> hdl/aligned_access_splitter.sv
// Flow: an event is accepted into the sequencer, then its first result is registered at
//   the output once that register is empty or draining; an access emits one aligned
//   chunk per cycle while the output is not stalled (1 to 11 chunks at the default
//   limit, sized by the chunk sizer/adder); the input waits for each event's last result.
// Reset: asynchronous, active low; clears lock phase, translation flag, stall flag and
//   outstanding count, zeroes thread_id and has_instruction_port, window base 0xF0000000.
module aligned_access_splitter #(
  parameter int unsigned MAX_ACCESS_BYTES = aas_pkg::MaxAccessBytesDef,
  parameter int unsigned COUNT_WIDTH      = aas_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Event input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aas_pkg::in_item_t             in_data_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output aas_pkg::out_item_t            out_data_o,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aas_pkg::PaddrW-1:0]    paddr,
  input  logic [aas_pkg::ApbDataW-1:0]  pwdata,
  output logic [aas_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  // Clamp limit compared on one extra bit so limits from 128 to 255 never clamp
  localparam logic [aas_pkg::LenW:0] MaxLen = (aas_pkg::LenW + 1)'(MAX_ACCESS_BYTES);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  aas_pkg::cfg_t cfg;

  aas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer and architectural state
  logic                           state_q, state_d;
  logic [aas_pkg::OpcodeW-1:0]    op_q;
  logic                           wr_q, vnz_q;
  logic                           first_q, first_d;
  logic [1:0]                     lock_q, lock_d;
  logic                           xlate_q, xlate_d;
  logic                           stall_q, stall_d;
  logic [COUNT_WIDTH-1:0]         count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  aas_pkg::out_item_t             out_q, out_d;

  logic                           in_fire, emit;
  logic                           in_window;
  logic [aas_pkg::LenW-1:0]       len_clamped, len_eff;

  // Chunk sizer/adder
  logic                           chunk_step;
  logic [aas_pkg::AddrW-1:0]      chunk_addr;
  logic [aas_pkg::ReqBytesW-1:0]  chunk_inc;
  logic                           chunk_pending, chunk_last;
  logic                           locked;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  // While running, load a new result whenever the output register is empty or being drained
  assign emit       = (state_q == StRun) & (~out_valid_q | out_ready_i);

  // Drop accesses that hit the device window; clamp over-long ones
  assign in_window   = in_data_i.phys_address >=
                       aas_pkg::AddrW'(cfg.device_window_base);
  assign len_clamped = ({1'b0, in_data_i.byte_count} > MaxLen) ?
                       MaxLen[aas_pkg::LenW-1:0] : in_data_i.byte_count;
  assign len_eff     = (in_data_i.opcode == aas_pkg::OpAccess && !in_window) ?
                       len_clamped : '0;

  assign chunk_step = emit & (op_q == aas_pkg::OpAccess) & chunk_pending;

  aas_chunk u_chunk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_fire),
    .step_i    (chunk_step),
    .addr_i    (in_data_i.phys_address),
    .len_i     (len_eff),
    .addr_o    (chunk_addr),
    .inc_o     (chunk_inc),
    .pending_o (chunk_pending),
    .last_o    (chunk_last)
  );

  // Lock marking applies to the first chunk of an access only
  always_comb begin
    locked = 1'b0;
    lock_d = lock_q;
    if (chunk_step && first_q && vnz_q) begin
      if (lock_q == aas_pkg::LockReadPend && !wr_q) begin
        locked = 1'b1;
        lock_d = aas_pkg::LockWritePend;
      end else if (lock_q == aas_pkg::LockWritePend && wr_q) begin
        locked = 1'b1;
        lock_d = aas_pkg::LockNone;
      end
    end
    if (emit && op_q == aas_pkg::OpAtomicBegin) begin
      lock_d = aas_pkg::LockReadPend;
    end
  end

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    xlate_d     = xlate_q;
    stall_d     = stall_q;
    count_d     = count_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_fire) begin
      state_d = StRun;
      first_d = 1'b1;
    end

    if (emit) begin
      out_valid_d = 1'b1;
      if (chunk_step) begin
        // One aligned chunk: reads stall, writes release the stall
        stall_d = ~wr_q;
        if (~&count_q) begin
          count_d = count_q + COUNT_WIDTH'(1);
        end
        first_d = 1'b0;
        out_d.has_request         = 1'b1;
        out_d.req_address         = chunk_addr;
        out_d.req_bytes           = chunk_inc;
        out_d.req_write           = wr_q;
        out_d.req_locked          = locked;
        out_d.req_owner           = locked ? cfg.thread_id : '0;
        out_d.to_instruction_port = xlate_q & ~wr_q & cfg.has_instruction_port;
        out_d.last                = chunk_last;
        if (chunk_last) begin
          state_d = StIdle;
        end
      end else begin
        // Empty result: apply the event's effect, then report the state
        case (op_q)
          aas_pkg::OpXlateBegin: xlate_d = 1'b1;
          aas_pkg::OpRetired:    xlate_d = 1'b0;
          aas_pkg::OpResponse: begin
            if (count_q != '0) begin
              count_d = count_q - COUNT_WIDTH'(1);
            end
            if (count_d == '0) begin
              stall_d = 1'b0;
            end
          end
          default: ;
        endcase
        out_d.has_request         = 1'b0;
        out_d.req_address         = '0;
        out_d.req_bytes           = '0;
        out_d.req_write           = 1'b0;
        out_d.req_locked          = 1'b0;
        out_d.req_owner           = '0;
        out_d.to_instruction_port = 1'b0;
        out_d.last                = 1'b1;
        state_d                   = StIdle;
      end
      out_d.stall_now       = stall_d;
      out_d.outstanding_now = aas_pkg::CountOutW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      first_q     <= 1'b0;
      lock_q      <= aas_pkg::LockNone;
      xlate_q     <= 1'b0;
      stall_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      lock_q      <= lock_d;
      xlate_q     <= xlate_d;
      stall_q     <= stall_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the event's control fields for the duration of the split
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= in_data_i.opcode;
      wr_q  <= in_data_i.is_write;
      vnz_q <= in_data_i.virt_nonzero;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/sv/tb_aligned_access_splitter.sv
`timescale 1ns / 1ps

module tb_aligned_access_splitter;
  import aas_pkg::*;

  // Opcodes the block treats as no-ops; they have no name in the package
  localparam logic [OpcodeW-1:0] OpSpareLo = 3'd5;
  localparam logic [OpcodeW-1:0] OpSpareHi = 3'd7;

  localparam int unsigned MaxBytes   = MaxAccessBytesDef;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned LongHold   = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PaddrW-1:0]   paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  aligned_access_splitter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 10 ns clock: low half, then high half
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Splitter shadow: register copy plus the block's lock, translation, stall
  // and outstanding-count state
  // ---------------------------------------------------------------------------
  cfg_t                 cfg_shadow;
  logic [1:0]           lock_ph = LockNone;
  logic                 xlate_on = 1'b0;
  logic [CountOutW-1:0] pend_cnt = '0;
  logic                 stall_on = 1'b0;

  out_item_t step_res[$];          // chunks produced by the latest event
  out_item_t predicted_req_q[$];   // chunks still owed by the block, oldest first

  int unsigned n_sent = 0;
  int unsigned n_directed = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_phases = 1;
  int unsigned cycle_cnt = 0;

  bit gaps_on = 1'b1;
  bit calm = 1'b0;           // set for the tail of the run: no idling on either side
  bit long_hold_req = 1'b0;  // ask the receiver for one long hold-off

  function automatic out_item_t mk_empty(input logic stall, input logic [CountOutW-1:0] cnt);
    out_item_t r;
    r = '0;
    r.stall_now = stall;
    r.outstanding_now = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  // Split one event into the chunks the block must emit, and advance the shadow state
  function automatic void split_event(input in_item_t ev);
    int unsigned len;
    int unsigned off;
    int unsigned step;
    logic [AddrW-1:0] a;
    logic locked;
    out_item_t r;
    step_res.delete();
    case (ev.opcode)
      OpAccess: begin
        len = int'(ev.byte_count);
        // Drop device-window accesses, clamp over-long ones
        if (ev.phys_address >= 64'(cfg_shadow.device_window_base)) len = 0;
        if (len > MaxBytes) len = MaxBytes;
        off = 0;
        while (off < len) begin
          a = ev.phys_address + 64'(off);
          // Take the largest naturally aligned size that still fits
          if (len - off >= 8 && a[2:0] == 3'b000) step = 8;
          else if (len - off >= 4 && a[1:0] == 2'b00) step = 4;
          else if (len - off >= 2 && a[0] == 1'b0) step = 2;
          else step = 1;
          locked = 1'b0;
          // Only the first chunk of an access can carry the lock
          if (off == 0 && ev.virt_nonzero) begin
            if (lock_ph == LockReadPend && !ev.is_write) begin
              locked = 1'b1;
              lock_ph = LockWritePend;
            end else if (lock_ph == LockWritePend && ev.is_write) begin
              locked = 1'b1;
              lock_ph = LockNone;
            end
          end
          stall_on = !ev.is_write;
          if (pend_cnt != '1) pend_cnt = pend_cnt + 1'b1;
          off += step;
          r = '0;
          r.has_request = 1'b1;
          r.req_address = a;
          r.req_bytes = 4'(step);
          r.req_write = ev.is_write;
          r.req_locked = locked;
          r.req_owner = locked ? cfg_shadow.thread_id : '0;
          r.to_instruction_port = xlate_on && !ev.is_write && cfg_shadow.has_instruction_port;
          r.stall_now = stall_on;
          r.outstanding_now = pend_cnt;
          r.last = (off >= len);
          step_res.push_back(r);
        end
      end
      OpAtomicBegin: lock_ph = LockReadPend;
      OpXlateBegin:  xlate_on = 1'b1;
      OpRetired:     xlate_on = 1'b0;
      OpResponse: begin
        if (pend_cnt != '0) pend_cnt = pend_cnt - 1'b1;
        if (pend_cnt == '0) stall_on = 1'b0;
      end
      default: ;
    endcase
    // Every event that makes no chunk still yields one empty result
    if (step_res.size() == 0) step_res.push_back(mk_empty(stall_on, pend_cnt));
  endfunction

  function automatic in_item_t mk_ev(input logic [OpcodeW-1:0] op, input logic [AddrW-1:0] addr,
                                     input logic [LenW-1:0] n, input logic wr, input logic vnz);
    in_item_t ev;
    ev.opcode = op;
    ev.phys_address = addr;
    ev.byte_count = n;
    ev.is_write = wr;
    ev.virt_nonzero = vnz;
    return ev;
  endfunction

  // Mostly below the window so that accesses split; now and then anywhere, or at the base
  function automatic logic [AddrW-1:0] rand_addr();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return 64'(cfg_shadow.device_window_base);
    if (cfg_shadow.device_window_base == '0) return {32'h0, $urandom};
    return {32'h0, 32'($urandom_range(0, cfg_shadow.device_window_base - 1))};
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    if ($urandom_range(0, 5) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, 16));
  endfunction

  function automatic void check_field(input string tag, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, tag, want, got);
      n_errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Event sender. Called at a falling edge; returns at the falling edge after the
  // transfer, with valid still high so back-to-back events need no dead cycle.
  // ---------------------------------------------------------------------------
  task automatic push_event(input in_item_t ev, input bit typed, input out_item_t want);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    split_event(ev);
    // Hand-written rows stand in for the shadow's answer; state still advances
    if (typed) predicted_req_q.push_back(want);
    else foreach (step_res[k]) predicted_req_q.push_back(step_res[k]);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [ApbDataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegThreadId:   cfg_shadow.thread_id = val[OwnerW-1:0];
      RegHasIport:   cfg_shadow.has_instruction_port = val[0];
      RegWindowBase: cfg_shadow.device_window_base = val[WindowW-1:0];
      default: ;
    endcase
    // Keep the bus idle so the next setup phase is its own step
    @(negedge clk);
  endtask

  // Reprogram all registers, only once the block has drained
  task automatic set_config(input logic [OwnerW-1:0] tid, input logic iport,
                            input logic [WindowW-1:0] base);
    in_valid <= 1'b0;
    do @(negedge clk); while (predicted_req_q.size() != 0);
    repeat (4) @(negedge clk);
    apb_write(RegThreadId, 32'(tid));
    apb_write(RegHasIport, 32'(iport));
    apb_write(RegWindowBase, base);
    n_phases++;
  endtask

  // Random traffic built mostly from well-formed sequences with random content
  task automatic random_burst(input int unsigned items);
    int unsigned stop_at;
    stop_at = n_sent + items;
    while (n_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // atomic begin, then the read and the write that can pick up the lock
          push_event(mk_ev(OpAtomicBegin, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                     1'b0, '0);
          push_event(mk_ev(OpAccess, rand_addr(), rand_len(), 1'b0, $urandom_range(0, 5) != 0),
                     1'b0, '0);
          push_event(mk_ev(OpAccess, rand_addr(), rand_len(), 1'b1, $urandom_range(0, 5) != 0),
                     1'b0, '0);
        end
        2, 3: begin
          // translation window around a few accesses
          push_event(mk_ev(OpXlateBegin, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                     1'b0, '0);
          repeat ($urandom_range(1, 3))
            push_event(mk_ev(OpAccess, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                       1'b0, '0);
          push_event(mk_ev(OpRetired, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                     1'b0, '0);
        end
        4, 5, 6: begin
          repeat ($urandom_range(1, 4))
            push_event(mk_ev(OpResponse, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                       1'b0, '0);
        end
        7, 8: begin
          push_event(mk_ev(OpAccess, rand_addr(), rand_len(), 1'($urandom), 1'($urandom)),
                     1'b0, '0);
        end
        default: begin
          // noise: any opcode, any field value
          push_event(mk_ev(3'($urandom_range(0, 7)), {$urandom, $urandom},
                           7'($urandom_range(0, 127)), 1'($urandom), 1'($urandom)), 1'b0, '0);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, clean stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned free_left;
    hold_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0) begin
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          hold_left = LongHold;
        end else if (free_left > 0) begin
          free_left--;
        end else if (!calm) begin
          case ($urandom_range(0, 9))
            0:       hold_left = $urandom_range(1, 13);
            1:       free_left = $urandom_range(15, 40);
            default: ;
          endcase
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each transfer on the result side against the oldest owed chunk
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (predicted_req_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual 0x%0h", $time, out_data);
        n_errors++;
      end else begin
        want = predicted_req_q.pop_front();
        check_field("has_request", 64'(want.has_request), 64'(out_data.has_request));
        check_field("req_address", want.req_address, out_data.req_address);
        check_field("req_bytes", 64'(want.req_bytes), 64'(out_data.req_bytes));
        check_field("req_write", 64'(want.req_write), 64'(out_data.req_write));
        check_field("req_locked", 64'(want.req_locked), 64'(out_data.req_locked));
        check_field("req_owner", 64'(want.req_owner), 64'(out_data.req_owner));
        check_field("to_instruction_port", 64'(want.to_instruction_port),
                    64'(out_data.to_instruction_port));
        check_field("stall_now", 64'(want.stall_now), 64'(out_data.stall_now));
        check_field("outstanding_now", 64'(want.outstanding_now),
                    64'(out_data.outstanding_now));
        check_field("last", 64'(want.last), 64'(out_data.last));
      end
    end
  end

  // Watchdog: end the run if it goes far past the slowest legal schedule
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_req_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  initial begin : stimulus
    out_item_t chunk8;
    cfg_shadow.thread_id = ThreadIdRst;
    cfg_shadow.has_instruction_port = HasIportRst;
    cfg_shadow.device_window_base = WindowBaseRst;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One aligned 8-byte read, expected as a single chunk
    chunk8 = '0;
    chunk8.has_request = 1'b1;
    chunk8.req_address = 64'h1000;
    chunk8.req_bytes = 4'd8;
    chunk8.stall_now = 1'b1;
    chunk8.outstanding_now = 16'd1;
    chunk8.last = 1'b1;

    // Rows with a typed result sit first, while the state is still known at a glance
    dir_tab.push_back('{mk_ev(OpResponse, 64'h0, 7'd0, 1'b0, 1'b0), 1'b1, mk_empty(1'b0, 16'd0)});
    dir_tab.push_back('{mk_ev(OpSpareHi, '1, '1, 1'b1, 1'b1), 1'b1, mk_empty(1'b0, 16'd0)});
    dir_tab.push_back('{mk_ev(OpAccess, 64'hF000_0000, 7'd8, 1'b0, 1'b0), 1'b1,
                        mk_empty(1'b0, 16'd0)});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h100, 7'd0, 1'b0, 1'b1), 1'b1, mk_empty(1'b0, 16'd0)});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h1000, 7'd8, 1'b0, 1'b0), 1'b1, chunk8});
    dir_tab.push_back('{mk_ev(OpResponse, 64'h0, 7'd0, 1'b0, 1'b0), 1'b1, mk_empty(1'b0, 16'd0)});
    // Lock walk: a write before the read, a read without virtual address, then the pair
    dir_tab.push_back('{mk_ev(OpAtomicBegin, 64'h0, 7'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h2003, 7'd13, 1'b1, 1'b1), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h2003, 7'd13, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h2003, 7'd13, 1'b0, 1'b1), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h2005, 7'd13, 1'b1, 1'b1), 1'b0, '0});
    // Translation with no instruction port, an over-long read, a one-byte write at zero
    dir_tab.push_back('{mk_ev(OpXlateBegin, 64'h0, 7'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h3001, 7'd127, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'h0, 7'd1, 1'b1, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpRetired, 64'h0, 7'd0, 1'b0, 1'b0), 1'b0, '0});
    // Address extremes: all ones is dropped, just under the window still splits
    dir_tab.push_back('{mk_ev(OpAccess, '1, 7'd64, 1'b0, 1'b1), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'hEFFF_FFFF, 7'd64, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpAccess, 64'hEFFF_FFF8, 7'd64, 1'b1, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpResponse, '1, '1, 1'b1, 1'b1), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpResponse, 64'h0, 7'd0, 1'b0, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_ev(OpSpareLo, 64'h5555_5555_5555_5555, 7'h2A, 1'b0, 1'b1), 1'b0, '0});

    foreach (dir_tab[k]) push_event(dir_tab[k].ev, dir_tab[k].typed, dir_tab[k].want);
    n_directed = n_sent;

    // Reset settings
    random_burst(16);

    // Owner all ones, instruction port present, window at the top
    set_config(8'hFF, 1'b1, 32'hFFFF_FFFF);
    // Hold off the receiver while the sender keeps offering: fill up and stall the input
    long_hold_req = 1'b1;
    gaps_on = 1'b0;
    random_burst(10);
    gaps_on = 1'b1;
    random_burst(14);

    // Window at zero: every access is dropped
    set_config(8'h00, 1'b0, 32'h0000_0000);
    random_burst(6);

    set_config(8'($urandom_range(1, 254)), 1'b1, 32'h0004_0000);
    random_burst(10);
    // Pause the sender until the block has delivered everything
    in_valid <= 1'b0;
    do @(negedge clk); while (predicted_req_q.size() != 0);
    random_burst(8);

    // Tail of the run at full rate on both sides
    calm = 1'b1;
    random_burst(14);
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray result
    while (predicted_req_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d events (%0d directed) over %0d register settings; %0d results checked.",
             n_sent, n_directed, n_phases, n_results);
    $display("Exercised lock marking, translation routing, window drops, clamping and stalls.");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/aas_pkg.sv
hdl/aas_cfg.sv
hdl/aas_chunk.sv
hdl/aligned_access_splitter.sv
tb/sv/tb_aligned_access_splitter.sv
